// ----- rtl/core/trial_division_prime_test_assert.svh -----
// ----------------------------------------------------------------------------
// Trial division prime test assertion macros
// Shared property shorthands for the prime test core.
// ----------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TDPT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define TDPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/tdpt_pkg.sv -----
// ----------------------------------------------------------------------------
// Trial division prime test package
// Default width and fixed constants of the prime test core.
// ----------------------------------------------------------------------------
package tdpt_pkg;

  localparam int WIDTH_DEF   = 32;
  localparam int FIRST_ODD   = 3;
  localparam int FIRST_PRIME = 2;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_NEXT  = 4'b1000
  } state_t;

endpackage

// ----- rtl/core/trial_division_prime_test.sv -----
// Results for 0, 1, 2 and even numbers come straight from idle; otherwise the
// core tries divisors from three up to floor(sqrt(number)), stopping on a hit.
// Throughput: one transaction at a time; each trial divisor costs one WIDTH-step
// restoring remainder pass of the shared subtract-compare unit plus ST_NEXT and ST_CHECK.
// Reset: synchronous active-high rst returns to idle with no result pending.
// The result strobe (done) lasts one cycle and is never held off.
// ----------------------------------------------------------------------------
// Trial division prime test
// Tests one unsigned number for primality by odd-and-even trial division.
// ----------------------------------------------------------------------------
`include "trial_division_prime_test_assert.svh"

module trial_division_prime_test #(
  parameter int WIDTH = tdpt_pkg::WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [WIDTH-1:0] number,
  output logic             done,
  output logic             is_prime
);

  localparam int SQW = WIDTH + 2;
  localparam int CW  = (WIDTH > 2) ? $clog2(WIDTH) : 1;

  tdpt_pkg::state_t state;

  logic [WIDTH-1:0] num;
  logic [WIDTH-1:0] sh;
  logic [WIDTH-1:0] d;
  logic [SQW-1:0]   sq;
  logic [WIDTH:0]   rem;
  logic [CW-1:0]    cnt;

  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   d_ext;
  logic             fits;
  logic [WIDTH:0]   rem_next;
  logic [SQW-1:0]   sq_next;
  logic [SQW-1:0]   num_ext;

  // shared subtract-compare unit
  assign trial    = {rem[WIDTH-1:0], sh[WIDTH-1]};
  assign d_ext    = {1'b0, d};
  assign fits     = (trial >= d_ext);
  assign rem_next = fits ? (trial - d_ext) : trial;

  assign sq_next  = sq + {{(SQW-WIDTH-1){1'b0}}, d, 1'b1};
  assign num_ext  = {2'b00, num};

  assign busy = (state != tdpt_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tdpt_pkg::ST_IDLE;
      done     <= 1'b0;
      is_prime <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        tdpt_pkg::ST_IDLE: begin
          if (start) begin
            num <= number;
            d   <= WIDTH'(tdpt_pkg::FIRST_ODD);
            sq  <= SQW'(tdpt_pkg::FIRST_ODD * tdpt_pkg::FIRST_ODD);
            if (number < WIDTH'(tdpt_pkg::FIRST_PRIME)) begin
              done     <= 1'b1;
              is_prime <= 1'b0;
            end else if (number == WIDTH'(tdpt_pkg::FIRST_PRIME)) begin
              done     <= 1'b1;
              is_prime <= 1'b1;
            end else if (!number[0]) begin
              done     <= 1'b1;
              is_prime <= 1'b0;
            end else begin
              state <= tdpt_pkg::ST_CHECK;
            end
          end
        end
        tdpt_pkg::ST_CHECK: begin
          if (sq > num_ext) begin
            done     <= 1'b1;
            is_prime <= 1'b1;
            state    <= tdpt_pkg::ST_IDLE;
          end else begin
            rem   <= '0;
            sh    <= num;
            cnt   <= CW'(WIDTH - 1);
            state <= tdpt_pkg::ST_DIV;
          end
        end
        tdpt_pkg::ST_DIV: begin
          rem <= rem_next;
          sh  <= {sh[WIDTH-2:0], 1'b0};
          cnt <= cnt - CW'(1);
          if (cnt == '0) begin
            state <= tdpt_pkg::ST_NEXT;
          end
        end
        tdpt_pkg::ST_NEXT: begin
          if (rem == '0) begin
            done     <= 1'b1;
            is_prime <= 1'b0;
            state    <= tdpt_pkg::ST_IDLE;
          end else begin
            d     <= d + WIDTH'(1);
            sq    <= sq_next;
            state <= tdpt_pkg::ST_CHECK;
          end
        end
        default: begin
          state <= tdpt_pkg::ST_IDLE;
        end
      endcase
    end
  end

  `TDPT_ASSERT_NEXT(a_accept_progress, clk, rst, start && !busy, busy || done, "accepted transaction neither working nor finished")
  `TDPT_ASSERT_NOW(a_done_idle, clk, rst, done, !busy, "result strobe while still busy")
  `TDPT_ASSERT_NOW(a_rem_below_d, clk, rst, (state == tdpt_pkg::ST_DIV) || (state == tdpt_pkg::ST_NEXT), rem < d_ext, "remainder not below divisor")
  `TDPT_ASSERT_NOW(a_div_floor, clk, rst, state == tdpt_pkg::ST_CHECK, d >= WIDTH'(tdpt_pkg::FIRST_ODD), "trial divisor below three")

endmodule

// ----- tb/trial_division_prime_test_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Trial division prime test bench
// Drives numbers into the prime test core with random start gaps and checks
// every prime verdict in order against an in-bench trial-division predictor.
// A directed set covers the boundary numbers, then random numbers follow,
// biased toward values whose test finishes quickly.
// ----------------------------------------------------------------------------
module trial_division_prime_test_tb;

  localparam int WIDTH = tdpt_pkg::WIDTH_DEF;
  localparam int RANDOM_COUNT = 100;
  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int DRAIN_CYCLES = WIDTH + 8;

  class prime_scoreboard;
    bit expected_verdicts[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    task report(input string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    function bit prime_by_division(input logic [WIDTH-1:0] value);
      longint unsigned n;
      longint unsigned d;
      n = value;
      if (n < tdpt_pkg::FIRST_PRIME) return 1'b0;
      if (n == tdpt_pkg::FIRST_PRIME) return 1'b1;
      if ((n % tdpt_pkg::FIRST_PRIME) == 0) return 1'b0;
      for (d = tdpt_pkg::FIRST_ODD; d <= n / d; d++) begin
        if ((n % d) == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_number(input logic [WIDTH-1:0] value);
      expected_verdicts.push_back(prime_by_division(value));
    endfunction

    task check_verdict(input logic got);
      bit want;
      if (expected_verdicts.size() == 0) begin
        report($sformatf("unexpected result is_prime=%0b", got));
      end else begin
        want = expected_verdicts.pop_front();
        if (got !== want)
          report($sformatf("is_prime got %0b want %0b", got, want));
      end
    endtask

    function int pending();
      return expected_verdicts.size();
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic [WIDTH-1:0] number;
  logic             done;
  logic             is_prime;

  prime_scoreboard sb;
  int unsigned     cycles;

  trial_division_prime_test #(.WIDTH(WIDTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .number   (number),
    .done     (done),
    .is_prime (is_prime)
  );

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    number = '0;
    cycles = 0;
    sb = new();
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_number(number);
      if (done) sb.check_verdict(is_prime);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int unsigned idle_gap();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  function automatic logic [WIDTH-1:0] pick_number();
    int unsigned sel;
    int unsigned bits;
    logic [WIDTH-1:0] r;
    logic [WIDTH-1:0] p;
    sel = $urandom_range(0, 99);
    r = $urandom;
    if (sel < 45) begin
      bits = $urandom_range(1, 16);
      return r >> (WIDTH - bits);
    end
    if (sel < 55) return r >> (WIDTH - 20);
    if (sel < 75) return {r[WIDTH-1:1], 1'b0};
    p = $urandom_range(3, 97);
    return (r / p) * p;
  endfunction

  task automatic send_number(input logic [WIDTH-1:0] value);
    int unsigned gap;
    start <= 1'b1;
    number <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = idle_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  logic [WIDTH-1:0] directed[$] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25, 32'd49,
    32'd97, 32'd121, 32'd63001, 32'd65521, 32'd65536, 32'd1052651,
    32'd1048573, 32'd1000003, 32'h8000_0000, 32'hAAAA_AAAA,
    32'h5555_5555, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd15
  };

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_number(directed[i]);
    wait_drained();

    for (int i = 0; i < RANDOM_COUNT; i++) begin
      send_number(pick_number());
      if (i == RANDOM_COUNT / 2) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/tdpt_pkg.sv
rtl/core/trial_division_prime_test.sv
tb/trial_division_prime_test_tb.sv
